// ----- rtl/mu7_pkg.sv -----
// Shared types and constants for the modified UTF-7 decoder.
package mu7_pkg;

   localparam int QueueDepthDefault = 4;

   localparam logic [7:0] CharAmp   = 8'h26;
   localparam logic [7:0] CharDash  = 8'h2D;
   localparam logic [7:0] CharPlus  = 8'h2B;
   localparam logic [7:0] CharComma = 8'h2C;
   localparam logic [7:0] CharLowA  = 8'h61;
   localparam logic [7:0] CharLowZ  = 8'h7A;
   localparam logic [7:0] CharUpA   = 8'h41;
   localparam logic [7:0] CharUpZ   = 8'h5A;
   localparam logic [7:0] CharZero  = 8'h30;
   localparam logic [7:0] CharNine  = 8'h39;
   localparam logic [7:0] CharFirst = 8'h20;
   localparam logic [7:0] CharLast  = 8'h7E;

   localparam logic [2:0] ERR_NONE   = 3'd0;
   localparam logic [2:0] ERR_CHAR   = 3'd1;
   localparam logic [2:0] ERR_STRAY  = 3'd2;
   localparam logic [2:0] ERR_SYMBOL = 3'd3;
   localparam logic [2:0] ERR_END    = 3'd4;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       last_byte;
   } in_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic [2:0] error_code;
      logic       done_res;
   } out_type;

   // Classified byte handed from front to back.
   typedef struct packed {
      logic [7:0] byte_val;
      logic [5:0] sym_val;
      logic       is_sym;
      logic       is_dash;
      logic       is_amp;
      logic       is_print;
      logic       last_byte;
   } class_type;

endpackage

// ----- rtl/modified_utf7_decoder.sv -----
// Top level of the IMAP modified UTF-7 streaming decoder.
// An accepted byte is written into the queue, then its response beat is registered in the back end.
// Throughput: one byte per cycle while the response side does not stall; the
// mode/partial-byte register loop in the back end handles one classified byte each cycle.
// Reset: synchronous, active high; clears queue, decode mode and response valid.
// No clearing pass: the block takes beats in the first cycle after reset.
module modified_utf7_decoder #(
   parameter int QUEUE_DEPTH = mu7_pkg::QueueDepthDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  mu7_pkg::in_type  req_data,
   output logic             req_stall,
   output logic             rsp_valid,
   output mu7_pkg::out_type rsp_data,
   input  logic             rsp_stall
);

   // Front -> queue
   logic               push, q_full;
   mu7_pkg::class_type push_item;

   // Queue -> back
   logic               pop, head_valid;
   mu7_pkg::class_type head_item;

   // Front: classifies each byte (printable, '&', '-', base64 symbol value)
   // and stalls the request side only when the queue is full.
   mu7_front u_front (
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .q_full    (q_full),
      .push      (push),
      .push_item (push_item)
   );

   // Queue decouples request stalls from response stalls.
   mu7_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   // Back: runs the mode machine and holds the response in its output register.
   // It pops whenever that register is empty or being drained this cycle.
   mu7_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .rsp_stall  (rsp_stall)
   );

endmodule

// ----- rtl/mu7_front.sv -----
// Front end: accepts request beats and classifies each byte.
module mu7_front (
   input  logic               req_valid,
   input  mu7_pkg::in_type    req_data,
   output logic               req_stall,
   input  logic               q_full,
   output logic               push,
   output mu7_pkg::class_type push_item
);

   logic [7:0] c;
   logic       up, low, dig;

   assign c   = req_data.in_byte;
   assign up  = (c >= mu7_pkg::CharUpA)  && (c <= mu7_pkg::CharUpZ);
   assign low = (c >= mu7_pkg::CharLowA) && (c <= mu7_pkg::CharLowZ);
   assign dig = (c >= mu7_pkg::CharZero) && (c <= mu7_pkg::CharNine);

   always_comb begin
      push_item.byte_val  = c;
      push_item.is_dash   = (c == mu7_pkg::CharDash);
      push_item.is_amp    = (c == mu7_pkg::CharAmp);
      push_item.is_print  = (c >= mu7_pkg::CharFirst) && (c <= mu7_pkg::CharLast);
      push_item.last_byte = req_data.last_byte;
      push_item.is_sym    = up || low || dig || (c == mu7_pkg::CharPlus)
                            || (c == mu7_pkg::CharComma);
      priority if (up) begin
         push_item.sym_val = 6'(c - mu7_pkg::CharUpA);
      end else if (low) begin
         push_item.sym_val = 6'(c - mu7_pkg::CharLowA + 8'd26);
      end else if (dig) begin
         push_item.sym_val = 6'(c - mu7_pkg::CharZero + 8'd52);
      end else if (c == mu7_pkg::CharPlus) begin
         push_item.sym_val = 6'd62;
      end else begin
         push_item.sym_val = 6'd63;
      end
   end

   assign req_stall = q_full;
   assign push      = req_valid && !q_full;

endmodule

// ----- rtl/mu7_queue.sv -----
// Small FIFO of classified bytes between front and back.
module mu7_queue #(
   parameter int DEPTH = mu7_pkg::QueueDepthDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mu7_pkg::class_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output mu7_pkg::class_type head_item
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] PtrMax = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] CntMax = CntW'(DEPTH);

   mu7_pkg::class_type mem_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign full       = (count_ff == CntMax);
   assign head_valid = (count_ff != '0);
   assign head_item  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrMax) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrMax) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/mu7_back.sv -----
// Back end: mode machine, base64 assembly and the response register.
module mu7_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  mu7_pkg::class_type head_item,
   output logic               pop,
   output logic               rsp_valid,
   output mu7_pkg::out_type   rsp_data,
   input  logic               rsp_stall
);

   localparam logic [2:0] MODE_NORMAL = 3'd0;
   localparam logic [2:0] MODE_AMP    = 3'd1;
   localparam logic [2:0] MODE_D0     = 3'd2;
   localparam logic [2:0] MODE_D1     = 3'd3;
   localparam logic [2:0] MODE_D2     = 3'd4;
   localparam logic [2:0] MODE_D3     = 3'd5;
   localparam logic [2:0] MODE_ERR    = 3'd6;
   localparam logic [2:0] MODE_SPARE  = 3'd7;

   logic [2:0] mode_ff, mode_in, run_mode, mode_nx;
   logic [7:0] partial_ff, partial_in, part_nx;
   logic       rsp_valid_ff, rsp_valid_in;
   mu7_pkg::out_type rsp_data_ff, rsp_data_in;

   logic [7:0] ob;
   logic       vld, emit, do_run;
   logic [2:0] err;
   mu7_pkg::class_type it;

   assign it        = head_item;
   assign pop       = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      ob       = '0;
      vld      = 1'b0;
      err      = mu7_pkg::ERR_NONE;
      mode_nx  = mode_ff;
      part_nx  = partial_ff;
      do_run   = 1'b0;
      run_mode = mode_ff;
      unique case (mode_ff)
         MODE_ERR: begin
            if (it.last_byte) begin
               err = partial_ff[2:0];
            end
         end
         MODE_AMP: begin
            if (it.is_dash) begin
               ob      = mu7_pkg::CharAmp;
               vld     = 1'b1;
               mode_nx = MODE_NORMAL;
            end else begin
               do_run   = 1'b1;
               run_mode = MODE_D0;
               mode_nx  = MODE_D0;
            end
         end
         MODE_D0, MODE_D1, MODE_D2, MODE_D3: begin
            do_run = 1'b1;
         end
         MODE_NORMAL, MODE_SPARE: begin
            if (!it.is_print) begin
               err = mu7_pkg::ERR_CHAR;
            end else if (it.is_amp) begin
               mode_nx = MODE_AMP;
            end else begin
               ob  = it.byte_val;
               vld = 1'b1;
            end
         end
         default: ;
      endcase

      // Symbol handling inside a base64 run.
      if (do_run) begin
         if (it.is_dash) begin
            if (run_mode == MODE_D1) begin
               err = mu7_pkg::ERR_STRAY;
            end else begin
               mode_nx = MODE_NORMAL;
               part_nx = '0;
            end
         end else if (!it.is_sym) begin
            err = mu7_pkg::ERR_SYMBOL;
         end else begin
            unique case (run_mode)
               MODE_D0: begin
                  part_nx = {it.sym_val, 2'b00};
                  mode_nx = MODE_D1;
               end
               MODE_D1: begin
                  ob      = partial_ff | {6'd0, it.sym_val[5:4]};
                  vld     = 1'b1;
                  part_nx = {it.sym_val[3:0], 4'd0};
                  mode_nx = MODE_D2;
               end
               MODE_D2: begin
                  ob      = partial_ff | {4'd0, it.sym_val[5:2]};
                  vld     = 1'b1;
                  part_nx = {it.sym_val[1:0], 6'd0};
                  mode_nx = MODE_D3;
               end
               default: begin
                  ob      = partial_ff | {2'd0, it.sym_val};
                  vld     = 1'b1;
                  part_nx = '0;
                  mode_nx = MODE_D0;
               end
            endcase
         end
      end

      if (err == mu7_pkg::ERR_NONE && it.last_byte && mode_nx != MODE_NORMAL) begin
         err = mu7_pkg::ERR_END;
      end
      if (err != mu7_pkg::ERR_NONE) begin
         vld = 1'b0;
         ob  = '0;
      end
      if (it.last_byte) begin
         mode_nx = MODE_NORMAL;
         part_nx = '0;
      end else if (err != mu7_pkg::ERR_NONE) begin
         mode_nx = MODE_ERR;
         part_nx = {5'd0, err};
      end
      emit = vld || (err != mu7_pkg::ERR_NONE) || it.last_byte;
   end

   always_comb begin
      mode_in      = mode_ff;
      partial_in   = partial_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (pop) begin
         mode_in    = mode_nx;
         partial_in = part_nx;
         if (emit) begin
            rsp_valid_in           = 1'b1;
            rsp_data_in.out_byte   = ob;
            rsp_data_in.byte_valid = vld;
            rsp_data_in.error_code = err;
            rsp_data_in.done_res   = it.last_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_NORMAL;
         partial_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         partial_ff   <= partial_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // An error response never carries a data byte.
   a_err_no_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.error_code != mu7_pkg::ERR_NONE)
      |-> !rsp_data_ff.byte_valid && (rsp_data_ff.out_byte == 8'd0))
      else $error("error beat carries a data byte");

   // The last byte of a string returns the machine to its reset state.
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      pop && it.last_byte |=> (mode_ff == MODE_NORMAL) && (partial_ff == 8'd0))
      else $error("state not cleared after last byte");

   // While ignoring input the latched code is a real error code.
   a_err_latched: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_ERR) |-> (partial_ff == 8'd1) || (partial_ff == 8'd2)
      || (partial_ff == 8'd3) || (partial_ff == 8'd4))
      else $error("bad latched error code");

   // A pending response is not lost while the sink stalls.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("stalled response dropped");

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for the modified UTF-7 streaming decoder.
`timescale 1ns / 100ps

module tb;

   // Decoder state as tracked by the predictor.
   typedef enum logic [2:0] {
      MODE_TEXT  = 3'd0,   // plain printable text
      MODE_AMP   = 3'd1,   // '&' seen, waiting for '-' or the first symbol
      MODE_B64_0 = 3'd2,   // base64 run, next symbol starts a group of four
      MODE_B64_1 = 3'd3,
      MODE_B64_2 = 3'd4,
      MODE_B64_3 = 3'd5,
      MODE_FAULT = 3'd6    // error latched, dropping bytes until end of string
   } decode_mode_type;

   localparam int HoldCycles   = 200;   // long receiver hold-off for the fill test
   localparam int DrainLimit   = 5000;  // cycles allowed for the last results
   localparam int TailCycles   = 8;     // settle time after the last result
   localparam int ReportLimit  = 10;    // mismatches printed in full

   // Clock and reset; every input starts at a known value.
   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   mu7_pkg::in_type  req_data  = '0;
   logic             req_stall;
   logic             rsp_valid;
   mu7_pkg::out_type rsp_data;
   logic             rsp_stall = 1'b0;

   // Idle rates (percent of cycles) for each side, set per phase.
   int send_idle_pct = 0;
   int rsp_idle_pct  = 0;
   int rsp_hold_left = 0;

   // Predictor state and the store of decoded beats still owed by the block.
   decode_mode_type  dec_mode    = MODE_TEXT;
   logic [7:0]       dec_partial = '0;
   mu7_pkg::out_type expected_beats[$];

   // Run statistics.
   int fail_count    = 0;
   int bytes_sent    = 0;   // every accepted byte
   int live_bytes    = 0;   // accepted bytes that arrived with no error latched
   int strings_sent  = 0;
   int decoded_bytes = 0;
   int error_beats   = 0;

   modified_utf7_decoder i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

   // 8 ns period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   // 6-bit value of a modified base64 symbol; bit 6 set means not a symbol.
   function automatic logic [6:0] b64_value(input logic [7:0] c);
      if (c >= mu7_pkg::CharUpA && c <= mu7_pkg::CharUpZ)
         return 7'(c - mu7_pkg::CharUpA);
      if (c >= mu7_pkg::CharLowA && c <= mu7_pkg::CharLowZ)
         return 7'(c - mu7_pkg::CharLowA + 8'd26);
      if (c >= mu7_pkg::CharZero && c <= mu7_pkg::CharNine)
         return 7'(c - mu7_pkg::CharZero + 8'd52);
      if (c == mu7_pkg::CharPlus) return 7'd62;
      if (c == mu7_pkg::CharComma) return 7'd63;
      return 7'd64;
   endfunction

   // Advances the decoder state by one accepted byte and queues the beat it owes.
   function automatic void predict_decode(input mu7_pkg::in_type beat);
      logic [7:0]       c;
      logic [6:0]       digit;
      logic [7:0]       ob;
      logic             ob_valid;
      logic [2:0]       err;
      mu7_pkg::out_type res;
      c        = beat.in_byte;
      ob       = '0;
      ob_valid = 1'b0;
      err      = mu7_pkg::ERR_NONE;

      if (dec_mode == MODE_FAULT) begin
         // Dropped silently; only the closing byte reports the latched code.
         if (!beat.last_byte) return;
         err = dec_partial[2:0];
      end else if (dec_mode == MODE_AMP && c == mu7_pkg::CharDash) begin
         // "&-" is a literal ampersand.
         ob       = mu7_pkg::CharAmp;
         ob_valid = 1'b1;
         dec_mode = MODE_TEXT;
      end else if (dec_mode != MODE_TEXT) begin
         // Inside a run; a bare '&' turns its next byte into the first symbol.
         if (dec_mode == MODE_AMP) dec_mode = MODE_B64_0;
         if (c == mu7_pkg::CharDash) begin
            if (dec_mode == MODE_B64_1) begin
               err = mu7_pkg::ERR_STRAY;   // six bits cannot make a byte
            end else begin
               dec_mode    = MODE_TEXT;
               dec_partial = '0;  // leftover bits are dropped
            end
         end else begin
            digit = b64_value(c);
            if (digit[6]) begin
               err = mu7_pkg::ERR_SYMBOL;
            end else begin
               case (dec_mode)
                  MODE_B64_0: begin
                     dec_partial = {digit[5:0], 2'b00};
                     dec_mode    = MODE_B64_1;
                  end
                  MODE_B64_1: begin
                     ob          = dec_partial | {6'b0, digit[5:4]};
                     ob_valid    = 1'b1;
                     dec_partial = {digit[3:0], 4'b0000};
                     dec_mode    = MODE_B64_2;
                  end
                  MODE_B64_2: begin
                     ob          = dec_partial | {4'b0, digit[5:2]};
                     ob_valid    = 1'b1;
                     dec_partial = {digit[1:0], 6'b000000};
                     dec_mode    = MODE_B64_3;
                  end
                  default: begin
                     ob          = dec_partial | {2'b0, digit[5:0]};
                     ob_valid    = 1'b1;
                     dec_partial = '0;
                     dec_mode    = MODE_B64_0;
                  end
               endcase
            end
         end
      end else begin
         if (c < mu7_pkg::CharFirst || c > mu7_pkg::CharLast) begin
            err = mu7_pkg::ERR_CHAR;
         end else if (c == mu7_pkg::CharAmp) begin
            dec_mode = MODE_AMP;
         end else begin
            ob       = c;
            ob_valid = 1'b1;
         end
      end

      // An open run at the end of the string outranks the byte just decoded.
      if (err == mu7_pkg::ERR_NONE && beat.last_byte && dec_mode != MODE_TEXT)
         err = mu7_pkg::ERR_END;
      if (err != mu7_pkg::ERR_NONE) begin
         ob_valid = 1'b0;
         ob       = '0;
      end

      if (beat.last_byte) begin
         dec_mode    = MODE_TEXT;
         dec_partial = '0;
      end else if (err != mu7_pkg::ERR_NONE) begin
         dec_mode    = MODE_FAULT;
         dec_partial = {5'b0, err};
      end

      if (!ob_valid && err == mu7_pkg::ERR_NONE && !beat.last_byte) return;
      res.out_byte   = ob;
      res.byte_valid = ob_valid;
      res.error_code = err;
      res.done_res   = beat.last_byte;
      expected_beats.push_back(res);
   endfunction

   // ------------------------------------------------------------------
   // Result side: random stall, long hold-off on request, and the checker
   // ------------------------------------------------------------------

   // A pending hold-off wins over the random stall and is counted down here.
   always @(posedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_stall     <= 1'b1;
         rsp_hold_left <= rsp_hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   // Every accepted result beat is matched against the oldest expected beat.
   always @(posedge clock) begin
      mu7_pkg::out_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rsp_data.byte_valid) decoded_bytes++;
         if (rsp_data.error_code != mu7_pkg::ERR_NONE) error_beats++;
         if (expected_beats.size() == 0) begin
            fail_count++;
            if (fail_count <= ReportLimit)
               $display("%0t: unexpected beat: byte %h valid %b err %0d done %b",
                        $time, rsp_data.out_byte, rsp_data.byte_valid,
                        rsp_data.error_code, rsp_data.done_res);
         end else begin
            want = expected_beats.pop_front();
            if (rsp_data.out_byte !== want.out_byte ||
                rsp_data.byte_valid !== want.byte_valid ||
                rsp_data.error_code !== want.error_code ||
                rsp_data.done_res !== want.done_res)
            begin
               fail_count++;
               if (fail_count <= ReportLimit)
                  $display("%0t: expected %h/%b/%0d/%b got %h/%b/%0d/%b",
                           $time, want.out_byte, want.byte_valid, want.error_code,
                           want.done_res, rsp_data.out_byte, rsp_data.byte_valid,
                           rsp_data.error_code, rsp_data.done_res);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------

   // Offers one byte, holds it until the block takes it, then predicts.
   // Valid stays high between back-to-back beats; it only drops for a gap.
   task automatic send_byte(input logic [7:0] b, input logic last);
      int              gap;
      mu7_pkg::in_type beat;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      beat.in_byte   = b;
      beat.last_byte = last;
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
      if (dec_mode != MODE_FAULT) live_bytes++;
      if (last) strings_sent++;
      predict_decode(beat);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
   endtask

   function automatic logic [7:0] b64_symbol(input logic [5:0] v);
      if (v < 6'd26) return mu7_pkg::CharUpA + 8'(v);
      if (v < 6'd52) return mu7_pkg::CharLowA + 8'(v - 6'd26);
      if (v < 6'd62) return mu7_pkg::CharZero + 8'(v - 6'd52);
      if (v == 6'd62) return mu7_pkg::CharPlus;
      return mu7_pkg::CharComma;
   endfunction

   function automatic logic [7:0] random_printable();
      logic [7:0] c;
      do c = 8'($urandom_range(mu7_pkg::CharFirst, mu7_pkg::CharLast));
      while (c == mu7_pkg::CharAmp);
      return c;
   endfunction

   // Builds one string out of random segments. Most segments are well-formed
   // text, escaped ampersands and closed runs; the rest are raw noise bytes,
   // runs closed after a lone symbol, and runs left open.
   task automatic send_random_string();
      logic [7:0] text_q[$];
      int         segs;
      int         kind;
      int         n;
      segs = $urandom_range(1, 5);
      for (int s = 0; s < segs; s++) begin
         kind = $urandom_range(99);
         if (kind < 35) begin
            n = $urandom_range(1, 4);
            repeat (n) text_q.push_back(random_printable());
         end else if (kind < 50) begin
            text_q.push_back(mu7_pkg::CharAmp);
            text_q.push_back(mu7_pkg::CharDash);
         end else if (kind < 85) begin
            do n = $urandom_range(2, 9); while (n % 4 == 1);
            text_q.push_back(mu7_pkg::CharAmp);
            repeat (n) text_q.push_back(b64_symbol(6'($urandom_range(63))));
            if ($urandom_range(7) != 0) text_q.push_back(mu7_pkg::CharDash);
         end else if (kind < 93) begin
            text_q.push_back(8'($urandom_range(255)));
         end else begin
            n = ($urandom_range(1) != 0) ? 5 : 1;
            text_q.push_back(mu7_pkg::CharAmp);
            repeat (n) text_q.push_back(b64_symbol(6'($urandom_range(63))));
            text_q.push_back(mu7_pkg::CharDash);
         end
      end
      foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   task automatic test_directed();
      send_byte(8'h00, 1'b0);   // control byte: invalid character
      send_byte(8'hFF, 1'b1);   // dropped, closes with the latched code
      send_text(" ~");          // printable extremes pass through
      send_text("&-");          // escaped ampersand
      send_text("&,,,,-");      // all-ones group, closed on a group boundary
      send_text("&A,-");        // closed after two symbols, leftover dropped
      send_text("&A-");         // dash after a lone symbol
      send_text("&");           // string ends right after '&'
      send_text("&AB");         // open run at the end beats the decoded byte
      send_text("&!");          // non-symbol right after '&'
      send_text("&A&");         // '&' inside a run
   endtask

   task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int n_bytes);
      int target;
      send_idle_pct = tx_pct;
      rsp_idle_pct  = rx_pct;
      target        = bytes_sent + n_bytes;
      while (bytes_sent < target) send_random_string();
   endtask

   // Receiver holds off for a long stretch while bytes keep coming, so the
   // internal queue fills and the block has to stall its input.
   task automatic test_receiver_hold();
      int target;
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      rsp_hold_left = HoldCycles;
      target        = bytes_sent + 60;
      while (bytes_sent < target) send_random_string();
   endtask

   task automatic drain_results();
      int waited;
      req_valid <= 1'b0;
      waited = 0;
      while (expected_beats.size() != 0 && waited < DrainLimit) begin
         @(posedge clock);
         waited++;
      end
      repeat (TailCycles) @(posedge clock);
      if (expected_beats.size() != 0) begin
         $display("%0d expected result beats never arrived", expected_beats.size());
         fail_count += expected_beats.size();
      end
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 20;
      rsp_idle_pct  = 53;
      test_directed();
      test_random_traffic(20, 53, 400);
      test_random_traffic(53, 20, 400);
      test_random_traffic(0, 0, 400);
      test_receiver_hold();
      drain_results();

      $display("Sent %0d bytes in %0d strings (%0d live): %0d bytes out, %0d error beats.",
               bytes_sent, strings_sent, live_bytes, decoded_bytes, error_beats);
      $display("Idle mixes covered: sender-light, receiver-light, none, plus a long hold-off.");
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d failures", fail_count);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Hard stop well past the slowest legal run.
   initial begin
      #2000000;
      $display("Timed out waiting on the block");
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
